[design/timed_playlist_slot_finder_top_defines.svh]
// Assertion macros for the timed playlist slot finder.
// Expects signals named clk and rst in the module that uses them.
`ifndef TIMED_PLAYLIST_SLOT_FINDER_TOP_DEFINES_SVH
`define TIMED_PLAYLIST_SLOT_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tps: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TPS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tps: next-cycle check failed");

`endif

[design/tps_pkg.sv]
// Shared types and constants for the timed playlist slot finder.
// No dependencies; used by every module of the block.
package tps_pkg;

  localparam int MAX_SLOTS_DEF = 256;
  localparam int TIME_W        = 64;
  localparam int DUR_W         = 32;
  localparam int CNT_W         = 9;
  localparam int SUM_W         = CNT_W + DUR_W;
  localparam int OUT_IDX_W     = 8;
  localparam int DIV_CNT_W     = $clog2(TIME_W);
  localparam int CFG_IDX_W     = 2;
  localparam int IN_DATA_W     = 176;
  localparam int OUT_DATA_W    = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_CNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORGIVING  = 2'd2;

  typedef enum logic [2:0] {
    OP_UPDATE   = 3'd0,
    OP_NEXT     = 3'd1,
    OP_PREV     = 3'd2,
    OP_JUMP     = 3'd3,
    OP_SET_LIVE = 3'd4,
    OP_LOAD     = 3'd5,
    OP_RESTART  = 3'd6
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_AVG,
    ST_QUO,
    ST_IDX,
    ST_POS,
    ST_WALK,
    ST_JMP,
    ST_MOD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [SUM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TIME_W-1:0] quo;
    logic [SUM_W-1:0]  rem;
  } div_rsp_t;

endpackage

[design/tps_mem.sv]
// Duration table: one write port, one read port with registered data.
// Depends on tps_pkg for the duration width.
module tps_mem import tps_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int AW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [DUR_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [DUR_W-1:0] rd_data
);

  logic [DUR_W-1:0] mem [MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/tps_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tps_pkg for the request and response structs.
module tps_div import tps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W-1:0]    quo;
  logic [SUM_W-1:0]     rem;
  logic [SUM_W-1:0]     dsr;
  logic [SUM_W:0]       shifted;
  logic                 fits;

  assign shifted = {rem, quo[TIME_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(TIME_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= fits ? SUM_W'(shifted - {1'b0, dsr}) : SUM_W'(shifted);
      quo <= {quo[TIME_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

  assign rsp = '{busy: busy, done: done, quo: quo, rem: rem};

endmodule

[design/timed_playlist_slot_finder_top.sv]
// Channel  | Dir | Signals                          | Moves
// s_*      | in  | s_tvalid s_tready s_tdata s_tuser | one op per transaction
// m_*      | out | m_tvalid m_tready m_tdata         | one result per op
// cfg_*    | in  | cfg_valid cfg_ready cfg_index cfg_data | register write
// A live update reads the table once per slot to sum it; precise mode then reads
// it again up to the matching slot. Both use the single table read port and the shared divider.
// Reset returns to live mode, clears the forgiving flag, slot and register state; the table is not cleared.
// A new op is taken while a finished result still waits on m_*.
// Depends on tps_pkg, tps_mem, tps_div and the assertion macro header.
`include "timed_playlist_slot_finder_top_defines.svh"
module timed_playlist_slot_finder_top import tps_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [63:0] time_ms, [127:64] step_count, [128] live_enable,
  // [136:129] entry_index, [168:137] slot_len_ms, rest zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [2:0] op
  input  logic [2:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] slot_index, [39:8] elapsed_in_slot_ms, [40] index_changed, rest zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TIME_W-1:0]     cfg_data
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  state_t state, state_next;

  logic [TIME_W-1:0] start_time_ms;
  logic [CNT_W-1:0]  entry_count;
  logic              forgiving_mode;
  logic              live_mode;
  logic [CNT_W-1:0]  last_slot;
  logic [CNT_W-1:0]  manual_slot;

  op_t               op_r;
  logic              jneg;
  logic [TIME_W-1:0] elapsed;
  logic [SUM_W-1:0]  total;
  logic [SUM_W-1:0]  pos;
  logic [SUM_W-1:0]  spent;
  logic [CNT_W-1:0]  rd_i;
  logic [CNT_W-1:0]  acc_i;
  logic              rd_vld;
  logic [CNT_W-1:0]  res_idx;
  logic [DUR_W-1:0]  res_off;
  logic              res_chg;

  logic              in_acc;
  logic              out_load;
  logic              step_ok;
  logic [CNT_W-1:0]  n_act;
  op_t               in_op;
  logic [TIME_W-1:0] in_time;
  logic [TIME_W-1:0] in_jump;
  logic              in_live;
  logic [7:0]        in_entry;
  logic [DUR_W-1:0]  in_dur;
  logic [TIME_W-1:0] jump_mag;
  logic [CNT_W-1:0]  jump_add;
  logic [CNT_W-1:0]  idle_idx;

  logic              rd_en;
  logic [DUR_W-1:0]  rd_data;
  logic [SUM_W-1:0]  eff;
  logic [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]  walk_next;
  logic              walk_hit;
  logic              mem_wr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_op    = op_t'(s_tuser);
  assign in_time  = s_tdata[63:0];
  assign in_jump  = s_tdata[127:64];
  assign in_live  = s_tdata[128];
  assign in_entry = s_tdata[136:129];
  assign in_dur   = s_tdata[168:137];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign out_load  = (state == ST_FIN) && (!m_tvalid || m_tready);

  assign n_act    = (32'(entry_count) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : entry_count;
  assign step_ok  = (n_act != '0) && !live_mode;
  assign jump_mag = in_jump[TIME_W-1] ? (TIME_W'(0) - in_jump) : in_jump;
  assign jump_add = !jneg ? div_rsp.rem[CNT_W-1:0] :
                    (div_rsp.rem == '0) ? '0 : (n_act - div_rsp.rem[CNT_W-1:0]);
  assign idle_idx = (n_act == '0) ? '0 : ((manual_slot < n_act) ? manual_slot : '0);

  assign mem_wr = in_acc && (in_op == OP_LOAD) && (32'(in_entry) < 32'(MAX_SLOTS));
  assign rd_en  = ((state == ST_SUM) || (state == ST_WALK)) && (rd_i < n_act);

  tps_mem #(.MAX_SLOTS(MAX_SLOTS), .AW(AW)) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr),
    .wr_addr(AW'(in_entry)),
    .wr_data(in_dur),
    .rd_en  (rd_en),
    .rd_addr(AW'(rd_i)),
    .rd_data(rd_data)
  );

  tps_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // zero-length slots count as one millisecond
  assign eff       = (rd_data == '0) ? SUM_W'(1) : SUM_W'(rd_data);
  assign sum_next  = total + eff;
  assign walk_next = spent + eff;
  assign walk_hit  = walk_next > pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_req    = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_FIN;
          priority if (in_op == OP_UPDATE && n_act != '0 && live_mode) begin
            state_next = ST_SUM;
          end else if (in_op == OP_NEXT && step_ok) begin
            div_req    = '{start: 1'b1, dividend: TIME_W'(manual_slot) + 1'b1,
                           divisor: SUM_W'(n_act)};
            state_next = ST_MOD;
          end else if (in_op == OP_JUMP && step_ok) begin
            div_req    = '{start: 1'b1, dividend: jump_mag, divisor: SUM_W'(n_act)};
            state_next = ST_JMP;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_SUM: begin
        if (rd_vld && acc_i == n_act - 1'b1) begin
          if (forgiving_mode) begin
            div_req    = '{start: 1'b1, dividend: TIME_W'(sum_next),
                           divisor: SUM_W'(n_act)};
            state_next = ST_AVG;
          end else begin
            div_req    = '{start: 1'b1, dividend: elapsed, divisor: sum_next};
            state_next = ST_POS;
          end
        end
      end
      ST_AVG: begin
        if (div_rsp.done) begin
          div_req    = '{start: 1'b1, dividend: elapsed, divisor: div_rsp.quo[SUM_W-1:0]};
          state_next = ST_QUO;
        end
      end
      ST_QUO: begin
        if (div_rsp.done) begin
          div_req    = '{start: 1'b1, dividend: div_rsp.quo, divisor: SUM_W'(n_act)};
          state_next = ST_IDX;
        end
      end
      ST_IDX: begin
        if (div_rsp.done) state_next = ST_FIN;
      end
      ST_POS: begin
        if (div_rsp.done) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (rd_vld && walk_hit) state_next = ST_FIN;
      end
      ST_JMP: begin
        if (div_rsp.done) begin
          div_req    = '{start: 1'b1,
                         dividend: TIME_W'(manual_slot) + TIME_W'(jump_add),
                         divisor: SUM_W'(n_act)};
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_rsp.done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time_ms  <= '0;
      entry_count    <= '0;
      forgiving_mode <= 1'b0;
      live_mode      <= 1'b1;
      last_slot      <= '0;
      manual_slot    <= '0;
      rd_vld         <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_START_TIME: start_time_ms  <= cfg_data;
          CFG_ENTRY_CNT:  entry_count    <= cfg_data[CNT_W-1:0];
          CFG_FORGIVING:  forgiving_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        unique case (in_op)
          OP_UPDATE: begin
            if (!(n_act != '0 && live_mode)) last_slot <= idle_idx;
          end
          OP_PREV: begin
            if (step_ok) begin
              manual_slot <= (manual_slot == '0) ? n_act - 1'b1 : manual_slot - 1'b1;
            end
          end
          OP_SET_LIVE: begin
            live_mode <= in_live;
            if (!in_live) manual_slot <= (last_slot < n_act) ? last_slot : '0;
          end
          OP_RESTART: begin
            live_mode   <= 1'b1;
            last_slot   <= '0;
            manual_slot <= '0;
          end
          default: ;
        endcase
      end
      if (state == ST_MOD && div_rsp.done) manual_slot <= div_rsp.rem[CNT_W-1:0];
      if (state == ST_IDX && div_rsp.done) last_slot <= div_rsp.rem[CNT_W-1:0];
      if (state == ST_WALK && rd_vld && walk_hit) last_slot <= acc_i;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rd_en) rd_i <= rd_i + 1'b1;
    acc_i <= rd_i;
    if (in_acc) begin
      op_r    <= in_op;
      jneg    <= in_jump[TIME_W-1];
      elapsed <= (in_time > start_time_ms) ? in_time - start_time_ms : '0;
      total   <= '0;
      rd_i    <= '0;
      res_idx <= idle_idx;
      res_off <= '0;
      res_chg <= (last_slot != idle_idx);
    end
    if (state == ST_SUM && rd_vld) total <= sum_next;
    if (state == ST_QUO && div_rsp.done) res_off <= div_rsp.rem[DUR_W-1:0];
    if (state == ST_IDX && div_rsp.done) begin
      res_idx <= div_rsp.rem[CNT_W-1:0];
      res_chg <= (last_slot != div_rsp.rem[CNT_W-1:0]);
    end
    if (state == ST_POS && div_rsp.done) begin
      pos   <= div_rsp.rem;
      spent <= '0;
      rd_i  <= '0;
    end
    if (state == ST_WALK && rd_vld) begin
      if (walk_hit) begin
        res_idx <= acc_i;
        res_off <= DUR_W'(pos - spent);
        res_chg <= (last_slot != acc_i);
      end else begin
        spent <= walk_next;
      end
    end
    if (out_load) begin
      if (op_r == OP_UPDATE) begin
        m_tdata <= {7'd0, res_chg, res_off, res_idx[OUT_IDX_W-1:0]};
      end else begin
        m_tdata <= {7'd0, 1'b0, 32'd0, manual_slot[OUT_IDX_W-1:0]};
      end
    end
  end

  `TPS_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy)
  `TPS_ASSERT_IMP(a_read_in_range, rd_vld, acc_i < n_act)
  `TPS_ASSERT_NXT(a_fin_holds, (state == ST_FIN) && m_tvalid && !m_tready, state == ST_FIN)

endmodule

[sim/tb.sv]
// Self-checking bench for timed_playlist_slot_finder_top: directed table, then random ops.
// Needs tps_pkg and the block's RTL; predicts every result with an in-bench slot model.
module tb;
  import tps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [2:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [TIME_W-1:0]     cfg_data = '0;

  always #4 clk = ~clk;

  timed_playlist_slot_finder_top u_dut (.*);

  typedef struct packed {
    logic [7:0]  slot;
    logic [31:0] elapsed;
    logic        changed;
  } slot_res_t;

  typedef struct {
    op_t         op;
    logic [63:0] tm;
    logic [63:0] steps;
    logic        live;
    logic [7:0]  idx;
    logic [31:0] dur;
    logic        chk;
    slot_res_t   want;
  } op_row_t;

  // predictor state
  logic [63:0] pm_start;
  logic [8:0]  pm_count;
  logic        pm_forgive;
  logic [31:0] pm_dur [256];
  logic [7:0]  pm_last, pm_manual;
  logic        pm_live;
  bit          pm_written [256];

  slot_res_t   pending_slots[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  int          n_ops = 0, n_updates = 0, n_results = 0;

  function automatic slot_res_t predict_slot(op_t op, logic [63:0] tm, logic [63:0] steps,
                                             logic live, logic [7:0] idx, logic [31:0] dur);
    slot_res_t   r;
    int unsigned n;
    logic [63:0] el, total, avg, pos, spent, nxt, s, add;
    n = (pm_count > 256) ? 256 : pm_count;
    r = '{default: '0};
    if (op == OP_UPDATE) begin
      if (n != 0 && !pm_live) begin
        r.slot = (pm_manual < n) ? pm_manual : 8'd0;
      end else if (n != 0) begin
        el = (tm > pm_start) ? tm - pm_start : 64'd0;
        total = 0;
        for (int i = 0; i < n; i++) total += (pm_dur[i] == 0) ? 64'd1 : 64'(pm_dur[i]);
        if (pm_forgive) begin
          avg = total / n;
          if (avg < 1) avg = 1;
          r.slot = 8'((el / avg) % n);
          r.elapsed = 32'(el % avg);
        end else begin
          pos = el % total;
          spent = 0;
          r.slot = 8'(n - 1);
          for (int i = 0; i < n; i++) begin
            nxt = spent + ((pm_dur[i] == 0) ? 64'd1 : 64'(pm_dur[i]));
            if (nxt > pos) begin
              r.slot = 8'(i);
              r.elapsed = 32'(pos - spent);
              break;
            end
            spent = nxt;
          end
        end
      end
      r.changed = (r.slot != pm_last);
      pm_last = r.slot;
      return r;
    end
    case (op)
      OP_NEXT: if (n != 0 && !pm_live) pm_manual = 8'((pm_manual + 1) % n);
      OP_PREV: if (n != 0 && !pm_live) pm_manual = (pm_manual == 0) ? 8'(n - 1) : pm_manual - 1;
      OP_JUMP: if (n != 0 && !pm_live) begin
        s = steps;
        if (s[63]) add = (n - ((0 - s) % n)) % n;
        else add = s % n;
        pm_manual = 8'((pm_manual + add) % n);
      end
      OP_SET_LIVE: begin
        pm_live = live;
        if (!live) pm_manual = (pm_last < n) ? pm_last : 8'd0;
      end
      OP_LOAD: begin
        pm_dur[idx] = dur;
        pm_written[idx] = 1'b1;
      end
      OP_RESTART: begin
        pm_live = 1'b1;
        pm_last = 0;
        pm_manual = 0;
      end
      default: ;
    endcase
    r.slot = pm_manual;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (ri)
      CFG_START_TIME: pm_start = val;
      CFG_ENTRY_CNT:  pm_count = val[8:0];
      CFG_FORGIVING:  pm_forgive = val[0];
      default: ;
    endcase
  endtask

  // drop the input request, then wait for every outstanding result
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // count must never exceed the number of table entries already loaded
  function automatic int loaded_prefix();
    int k;
    k = 0;
    while (k < 256 && pm_written[k]) k++;
    return k;
  endfunction

  // holds tvalid high after the transaction; the next gap or drain drops it
  task automatic send_op(op_row_t row);
    slot_res_t r;
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? 40 : $urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.op;
    s_tdata  <= {7'd0, row.dur, row.idx, row.live, row.steps, row.tm};
    do @(posedge clk); while (!s_tready);
    r = predict_slot(row.op, row.tm, row.steps, row.live, row.idx, row.dur);
    if (row.chk && r != row.want) begin
      $error("table row disagrees with predictor: slot %0d/%0d", row.want.slot, r.slot);
      errors++;
    end
    pending_slots.push_back(r);
    n_ops++;
    if (row.op == OP_UPDATE) n_updates++;
  endtask

  // result side: random stall, compare against oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready <= ($urandom_range(0, 99) < 20) ? 1'b0 : 1'b1;
        if ($urandom_range(0, 199) == 0) stall_left <= 30;
      end
      if (m_tvalid && m_tready) begin
        if (pending_slots.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          slot_res_t w;
          w = pending_slots.pop_front();
          n_results++;
          if (m_tdata[7:0] != w.slot) begin
            $error("slot_index expected %0d got %0d", w.slot, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[39:8] != w.elapsed) begin
            $error("elapsed_in_slot_ms expected %0d got %0d", w.elapsed, m_tdata[39:8]);
            errors++;
          end
          if (m_tdata[40] != w.changed) begin
            $error("index_changed expected %0d got %0d", w.changed, m_tdata[40]);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic op_row_t mk(op_t op, logic [63:0] tm = 0, logic [63:0] st = 0,
                                 logic lv = 0, logic [7:0] ix = 0, logic [31:0] du = 0);
    op_row_t row;
    row = '{op: op, tm: tm, steps: st, live: lv, idx: ix, dur: du, chk: 1'b0,
            want: '{default: '0}};
    return row;
  endfunction

  function automatic op_row_t mkc(op_row_t row, logic [7:0] sl, logic [31:0] el, logic ch);
    row.chk = 1'b1;
    row.want = '{slot: sl, elapsed: el, changed: ch};
    return row;
  endfunction

  initial begin
    op_row_t dir[$];
    op_row_t row;
    int k, sel;
    pm_start = 0; pm_count = 0; pm_forgive = 0;
    pm_last = 0; pm_manual = 0; pm_live = 1;
    foreach (pm_dur[i]) begin pm_dur[i] = 0; pm_written[i] = 0; end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty playlist and stepping that does nothing
    dir.push_back(mkc(mk(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF), 0, 0, 0));
    dir.push_back(mkc(mk(OP_NEXT), 0, 0, 0));
    dir.push_back(mkc(mk(OP_JUMP, 0, 64'h8000_0000_0000_0000), 0, 0, 0));
    dir.push_back(mkc(mk(OP_SET_LIVE, 0, 0, 1'b0), 0, 0, 0));
    dir.push_back(mkc(mk(OP_PREV), 0, 0, 0));
    dir.push_back(mk(OP_LOAD, 0, 0, 0, 8'd0, 32'd0));
    dir.push_back(mk(OP_LOAD, 0, 0, 0, 8'd1, 32'hFFFF_FFFF));
    dir.push_back(mk(OP_LOAD, 0, 0, 0, 8'd2, 32'd5));
    dir.push_back(mk(OP_LOAD, 0, 0, 0, 8'd255, 32'd7));
    dir.push_back(mkc(mk(OP_RESTART), 0, 0, 0));
    foreach (dir[i]) send_op(dir[i]);
    drain();
    write_reg(CFG_ENTRY_CNT, 64'd3);
    write_reg(CFG_START_TIME, 64'd100);
    dir.delete();
    dir.push_back(mkc(mk(OP_UPDATE, 64'd50), 0, 0, 0));
    dir.push_back(mkc(mk(OP_UPDATE, 64'd101), 1, 0, 1));
    dir.push_back(mk(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF));
    dir.push_back(mk(OP_NEXT));
    dir.push_back(mk(OP_SET_LIVE, 0, 0, 1'b0));
    dir.push_back(mk(OP_NEXT));
    dir.push_back(mk(OP_PREV));
    dir.push_back(mk(OP_PREV));
    dir.push_back(mk(OP_JUMP, 0, 64'h7FFF_FFFF_FFFF_FFFF));
    dir.push_back(mk(OP_JUMP, 0, 64'h8000_0000_0000_0000));
    dir.push_back(mk(OP_UPDATE, 64'd0));
    dir.push_back(mk(OP_SET_LIVE, 0, 0, 1'b1));
    dir.push_back(mk(OP_LOAD, 0, 0, 0, 8'd3, 32'd1));
    // undefined op code leaves the state alone
    dir.push_back(mk(op_t'(3'd7), 64'd12345));
    foreach (dir[i]) send_op(dir[i]);
    drain();

    // random phases with changing registers; occasional full-table phase
    for (int ph = 0; ph < 12; ph++) begin
      for (int e = 0; e < 256; e++)
        if (!pm_written[e] && (ph == 3 || e < 16)) begin
          row = mk(OP_LOAD, 0, 0, 0, 8'(e), $urandom_range(0, 3) == 0 ? 32'($urandom) :
                   32'($urandom_range(0, 2000)));
          send_op(row);
        end
      drain();
      k = loaded_prefix();
      case (ph % 4)
        0: write_reg(CFG_ENTRY_CNT, 64'($urandom_range(1, 16)));
        1: write_reg(CFG_ENTRY_CNT, 64'd1);
        2: write_reg(CFG_ENTRY_CNT, 64'(k));
        // count above the table size saturates once the whole table is loaded
        default: write_reg(CFG_ENTRY_CNT, (ph == 11) ? 64'd0 :
                           (ph == 7) ? 64'd400 : 64'($urandom_range(1, k)));
      endcase
      write_reg(CFG_FORGIVING, 64'(ph % 2));
      write_reg(CFG_START_TIME, (ph == 5) ? 64'hFFFF_FFFF_FFFF_FFFF :
                {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63));
      for (int i = 0; i < 30; i++) begin
        sel = $urandom_range(0, 99);
        row = mk(OP_UPDATE, pm_start + 64'($urandom_range(0, 100000)) - 64'd500);
        if (sel < 8) row.tm = {32'($urandom), 32'($urandom)};
        else if (sel < 20) row.op = OP_NEXT;
        else if (sel < 30) row.op = OP_PREV;
        else if (sel < 42) begin
          row.op = OP_JUMP;
          row.steps = {32'($urandom), 32'($urandom)} >>> $urandom_range(0, 63);
        end else if (sel < 52) begin
          row.op = OP_SET_LIVE;
          row.live = $urandom_range(0, 1);
        end else if (sel < 56) row.op = OP_RESTART;
        else if (sel < 62) begin
          row.op = OP_LOAD;
          row.idx = $urandom_range(0, 255);
          row.dur = $urandom;
        end
        row.steps = row.steps ^ ((row.op == OP_JUMP) ? 64'd0 : {32'($urandom), 32'($urandom)});
        send_op(row);
        if (i == 20 && ph == 2) drain();
      end
      drain();
    end

    drain();
    $display("Covered %0d ops (%0d updates), %0d results, empty/precise/forgiving/manual modes.",
             n_ops, n_updates, n_results);
    if (errors == 0 && pending_slots.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+design
design/tps_pkg.sv
design/tps_mem.sv
design/tps_div.sv
design/timed_playlist_slot_finder_top.sv
sim/tb.sv
